@@ rtl/core/dtsp_pkg.sv @@
// Package for the depth-tested scaled pixel plot core.
// Holds sizes, field widths, register indexes and command codes.
// No dependencies.
package dtsp_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_SCALE   = 8;

  localparam int POS_W       = 8;
  localparam int DEPTH_W     = 32;
  localparam int COLOR_W     = 24;
  localparam int COORD_W     = 11;
  localparam int SCALE_W     = 4;
  localparam int SIZE_W      = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int STEP_W      = $clog2(MAX_SCALE) > 0 ? $clog2(MAX_SCALE) : 1;

  localparam logic signed [DEPTH_W-1:0] DEPTH_FAR = {1'b1, {(DEPTH_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RENDER_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RENDER_HEIGHT = 2'd2;

  localparam logic CMD_PLOT  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

endpackage

@@ rtl/core/depth_tested_scaled_pixel_plot_core.sv @@
// Top level of the depth-tested scaled pixel plot core.
// Depends on dtsp_pkg; holds the depth memory, the control sequencer and the output word register.
//
// A plot word is checked against the render size, its depth is read from a 64K-entry
// depth memory (registered read, separate write port) and compared; a nearer plot writes its
// depth back and then emits scale*scale framebuffer words, one per cycle while out_ready
// allows, row by row, the final one marked with out_last. One word is handled at a time:
// a dropped plot leaves the core in idle, a hidden plot passes the read and test states,
// and a drawn plot passes read and test and then emits all its words before in_ready returns.
// After reset and after every clear word the core sweeps the whole depth memory, one entry
// per cycle, with in_ready low; configuration writes are taken throughout.
module depth_tested_scaled_pixel_plot_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dtsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtsp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [dtsp_pkg::POS_W-1:0]      in_pos_x,
  input  logic [dtsp_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [dtsp_pkg::DEPTH_W-1:0] in_depth,
  input  logic [dtsp_pkg::COLOR_W-1:0]    in_color,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dtsp_pkg::COORD_W-1:0]    out_x,
  output logic [dtsp_pkg::COORD_W-1:0]    out_y,
  output logic [dtsp_pkg::COLOR_W-1:0]    out_color,
  output logic                            out_last
);
  import dtsp_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_TEST  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [SCALE_W-1:0]       scale_cfg_r;
  logic [SIZE_W-1:0]        width_cfg_r, height_cfg_r;
  logic [ADDR_W-1:0]        clr_cnt_r;

  logic [ADDR_W-1:0]        idx_r;
  logic signed [DEPTH_W-1:0] depth_r;
  logic [COLOR_W-1:0]       color_r;
  logic [COORD_W-1:0]       base_x_r, base_y_r;
  logic [SCALE_W-1:0]       scale_r;
  logic [STEP_W-1:0]        col_r, row_r;

  logic signed [DEPTH_W-1:0] mem [STORE_DEPTH];
  logic signed [DEPTH_W-1:0] rd_data_r;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic signed [DEPTH_W-1:0] mem_wdata;

  logic                     out_valid_r;
  logic [COORD_W-1:0]       out_x_r, out_y_r;
  logic [COLOR_W-1:0]       out_color_r;
  logic                     out_last_r;

  logic [SIZE_W-1:0]        eff_w, eff_h;
  logic [SCALE_W-1:0]       eff_s;
  logic                     in_range;
  logic                     accept;
  logic                     out_free;
  logic                     col_end, row_end;
  logic                     emit_load;

  // effective configuration
  always_comb begin
    eff_w = (width_cfg_r > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_cfg_r;
    eff_h = (height_cfg_r > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_cfg_r;
    if (scale_cfg_r == '0) begin
      eff_s = SCALE_W'(1);
    end else if (scale_cfg_r > SCALE_W'(MAX_SCALE)) begin
      eff_s = SCALE_W'(MAX_SCALE);
    end else begin
      eff_s = scale_cfg_r;
    end
    in_range = ({1'b0, in_pos_x} < eff_w) && ({1'b0, in_pos_y} < eff_h);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign col_end   = (SCALE_W'(col_r) + SCALE_W'(1)) == scale_r;
  assign row_end   = (SCALE_W'(row_r) + SCALE_W'(1)) == scale_r;
  assign emit_load = (state_r == ST_EMIT) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (in_range) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: state_nxt = ST_TEST;
      ST_TEST: begin
        state_nxt = (depth_r > rd_data_r) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_load && col_end && row_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // depth memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = depth_r;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = DEPTH_FAR;
    end else if ((state_r == ST_TEST) && (depth_r > rd_data_r)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[idx_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      scale_cfg_r  <= SCALE_W'(1);
      width_cfg_r  <= SIZE_W'(256);
      height_cfg_r <= SIZE_W'(256);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end else begin
        clr_cnt_r <= '0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PIXEL_SCALE:   scale_cfg_r  <= cfg_data[SCALE_W-1:0];
          CFG_RENDER_WIDTH:  width_cfg_r  <= cfg_data[SIZE_W-1:0];
          CFG_RENDER_HEIGHT: height_cfg_r <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // plot word and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r    <= ADDR_W'({{(ADDR_W-POS_W){1'b0}}, in_pos_y}
                          * {{(ADDR_W-SIZE_W){1'b0}}, eff_w}) + ADDR_W'(in_pos_x);
      depth_r  <= in_depth;
      color_r  <= in_color;
      base_x_r <= COORD_W'({{(COORD_W-POS_W){1'b0}}, in_pos_x}
                           * {{(COORD_W-SCALE_W){1'b0}}, eff_s});
      base_y_r <= COORD_W'({{(COORD_W-POS_W){1'b0}}, in_pos_y}
                           * {{(COORD_W-SCALE_W){1'b0}}, eff_s});
      scale_r  <= eff_s;
      col_r    <= '0;
      row_r    <= '0;
    end
    if (emit_load) begin
      out_x_r     <= base_x_r + COORD_W'(col_r);
      out_y_r     <= base_y_r + COORD_W'(row_r);
      out_color_r <= color_r;
      out_last_r  <= col_end && row_end;
      if (col_end) begin
        col_r <= '0;
        row_r <= row_r + STEP_W'(1);
      end else begin
        col_r <= col_r + STEP_W'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_color = out_color_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/core/dtsp_checker.sv @@
// Port-level checker for the depth-tested scaled pixel plot core.
// Depends on dtsp_pkg; bound to depth_tested_scaled_pixel_plot_core below.
module dtsp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_command,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dtsp_pkg::COORD_W-1:0]    out_x,
  input logic [dtsp_pkg::COORD_W-1:0]    out_y,
  input logic [dtsp_pkg::COLOR_W-1:0]    out_color,
  input logic                            out_last
);
  import dtsp_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_color) && $stable(out_last))
    else $error("output word changed while stalled");

  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("core ready right after reset");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_CLEAR |=> !in_ready)
    else $error("core ready right after clear word");

  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_color == $past(out_color))
    else $error("plot burst broken before last word");

endmodule

bind depth_tested_scaled_pixel_plot_core dtsp_checker u_dtsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_command (in_command),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_color  (out_color),
  .out_last   (out_last)
);

@@ dv/dtsp_write_checker.sv @@
// Checker for the depth-tested scaled pixel plot core: mirrors the depth store and
// registers, predicts the framebuffer words of every accepted word and compares them.
// Depends on dtsp_pkg.
module dtsp_write_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dtsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_command,
  input  logic [dtsp_pkg::POS_W-1:0]          in_pos_x,
  input  logic [dtsp_pkg::POS_W-1:0]          in_pos_y,
  input  logic signed [dtsp_pkg::DEPTH_W-1:0] in_depth,
  input  logic [dtsp_pkg::COLOR_W-1:0]        in_color,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [dtsp_pkg::COORD_W-1:0]        out_x,
  input  logic [dtsp_pkg::COORD_W-1:0]        out_y,
  input  logic [dtsp_pkg::COLOR_W-1:0]        out_color,
  input  logic                                out_last,
  output int                                  errors,
  output int                                  pending
);
  import dtsp_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } fb_write_t;

  logic signed [DEPTH_W-1:0] depth_mem [STORE_DEPTH];
  logic [SCALE_W-1:0]        scale_q;
  logic [SIZE_W-1:0]         width_q;
  logic [SIZE_W-1:0]         height_q;
  fb_write_t                 fb_writes_q [$];

  task automatic wipe_depths();
    foreach (depth_mem[k]) depth_mem[k] = DEPTH_FAR;
  endtask

  task automatic predict_plot(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                              input logic signed [DEPTH_W-1:0] d,
                              input logic [COLOR_W-1:0] c);
    int s;
    int w;
    int h;
    int idx;
    fb_write_t wr;
    s = int'(scale_q);
    if (s > MAX_SCALE) s = MAX_SCALE;
    if (s == 0) s = 1;
    w = int'(width_q);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = int'(height_q);
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (int'(px) >= w || int'(py) >= h) return;
    idx = int'(py) * w + int'(px);
    if (d <= depth_mem[idx]) return;
    depth_mem[idx] = d;
    for (int i = 0; i < s; i++) begin
      for (int j = 0; j < s; j++) begin
        wr.x     = COORD_W'(int'(px) * s + j);
        wr.y     = COORD_W'(int'(py) * s + i);
        wr.color = c;
        wr.last  = (i == s - 1) && (j == s - 1);
        fb_writes_q.push_back(wr);
      end
    end
  endtask

  function automatic int check_write();
    fb_write_t exp_wr;
    int bad;
    bad = 0;
    if (fb_writes_q.size() == 0) begin
      $error("unexpected framebuffer word: x %0d, y %0d", out_x, out_y);
      return 1;
    end
    exp_wr = fb_writes_q.pop_front();
    if (out_x !== exp_wr.x) begin
      $error("out_x: expected %0d, actual %0d", exp_wr.x, out_x);
      bad++;
    end
    if (out_y !== exp_wr.y) begin
      $error("out_y: expected %0d, actual %0d", exp_wr.y, out_y);
      bad++;
    end
    if (out_color !== exp_wr.color) begin
      $error("out_color: expected %06h, actual %06h", exp_wr.color, out_color);
      bad++;
    end
    if (out_last !== exp_wr.last) begin
      $error("out_last: expected %0d, actual %0d", exp_wr.last, out_last);
      bad++;
    end
    return bad;
  endfunction

  always @(posedge clk) begin
    int n_bad;
    n_bad = 0;
    if (!rst_n) begin
      scale_q  = SCALE_W'(1);
      width_q  = SIZE_W'(MAX_WIDTH);
      height_q = SIZE_W'(MAX_HEIGHT);
      wipe_depths();
      fb_writes_q.delete();
    end else begin
      if (out_valid && out_ready) n_bad = check_write();
      if (in_valid && in_ready) begin
        if (in_command == CMD_CLEAR) wipe_depths();
        else predict_plot(in_pos_x, in_pos_y, in_depth, in_color);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PIXEL_SCALE:   scale_q = cfg_data[SCALE_W-1:0];
          CFG_RENDER_WIDTH:  width_q = cfg_data;
          CFG_RENDER_HEIGHT: height_q = cfg_data;
          default: ;
        endcase
      end
    end
    errors  <= errors + n_bad;
    pending <= fb_writes_q.size();
  end

endmodule

@@ dv/depth_tested_scaled_pixel_plot_core_tb.sv @@
// Testbench top for the depth-tested scaled pixel plot core: drives plot and clear words
// and register writes, stalls the framebuffer side, and reports the verdict.
// Depends on dtsp_pkg, the core and dtsp_write_checker.
module depth_tested_scaled_pixel_plot_core_tb;
  import dtsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0]      CFG_SPARE = 2'd3;
  localparam logic signed [DEPTH_W-1:0] DEPTH_NEAR = 32'sh7FFF_FFFF;
  localparam int CYCLE_LIMIT       = 2_000_000;
  localparam int DRAIN_CYCLES      = 8;
  localparam int RANDOM_PHASES     = 6;
  localparam int WORDS_PER_PHASE   = 49;
  localparam int MAX_RANDOM_CLEARS = 3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_command = CMD_PLOT;
  logic [POS_W-1:0]          in_pos_x = '0;
  logic [POS_W-1:0]          in_pos_y = '0;
  logic signed [DEPTH_W-1:0] in_depth = '0;
  logic [COLOR_W-1:0]        in_color = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [COORD_W-1:0]        out_x;
  logic [COORD_W-1:0]        out_y;
  logic [COLOR_W-1:0]        out_color;
  logic                      out_last;
  int                        errors;
  int                        pending;

  int                        burst_left = 0;
  int                        clears_left = MAX_RANDOM_CLEARS;
  int                        cur_width = MAX_WIDTH;
  int                        cur_height = MAX_HEIGHT;
  int                        stall_mode = 0;
  int                        stall_tick = 0;
  logic [POS_W-1:0]          prev_x = '0;
  logic [POS_W-1:0]          prev_y = '0;
  logic signed [DEPTH_W-1:0] prev_depth = '0;
  logic [COLOR_W-1:0]        prev_color = '0;

  depth_tested_scaled_pixel_plot_core dut (.*);

  dtsp_write_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_tick == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_tick = $urandom_range(20, 300);
    end
    stall_tick--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_tick % 4 == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    @(posedge clk);
  endtask

  task automatic load_config(input int scale, input int width, input int height);
    write_reg(CFG_PIXEL_SCALE, scale);
    write_reg(CFG_RENDER_WIDTH, width);
    write_reg(CFG_RENDER_HEIGHT, height);
    write_reg(CFG_SPARE, $urandom_range(0, 511));
    cfg_we     <= 1'b0;
    cur_width  = width;
    cur_height = height;
  endtask

  task automatic send_word(input logic cmd, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic signed [DEPTH_W-1:0] d,
                           input logic [COLOR_W-1:0] c);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_pos_x   <= x;
    in_pos_y   <= y;
    in_depth   <= d;
    in_color   <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    prev_x     = x;
    prev_y     = y;
    prev_depth = d;
    prev_color = c;
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic plot(input int x, input int y, input logic signed [DEPTH_W-1:0] d,
                      input int c);
    send_word(CMD_PLOT, POS_W'(x), POS_W'(y), d, COLOR_W'(c));
    pace();
  endtask

  task automatic clear_depths();
    send_word(CMD_CLEAR, POS_W'($urandom), POS_W'($urandom), $urandom, COLOR_W'($urandom));
    pace();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || !in_ready);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_word();
    int sel;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic signed [DEPTH_W-1:0] d;
    sel = $urandom_range(0, 99);
    if (clears_left > 0 && sel == 0) begin
      clears_left--;
      clear_depths();
      return;
    end
    if (sel < 8) begin
      plot(prev_x, prev_y, prev_depth, prev_color);
      return;
    end
    sel = $urandom_range(0, 9);
    x = POS_W'($urandom_range(0, 5));
    y = POS_W'($urandom_range(0, 5));
    if (sel == 7 || sel == 8) begin
      x = POS_W'($urandom);
      y = POS_W'($urandom);
    end else if (sel == 9) begin
      if ($urandom_range(0, 1) == 0) x = POS_W'(cur_width);
      else y = POS_W'(cur_height);
    end
    case ($urandom_range(0, 9))
      0: d = DEPTH_FAR;
      1: d = DEPTH_NEAR;
      2: d = DEPTH_W'(int'($urandom_range(0, 15)) - 8);
      default: d = $urandom;
    endcase
    plot(x, y, d, $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    plot(0, 0, DEPTH_FAR, 24'h123456);
    plot(0, 0, DEPTH_FAR + 1, 24'h000000);
    plot(0, 0, DEPTH_FAR + 1, 24'h00FF00);
    plot(255, 255, DEPTH_NEAR, 24'hFFFFFF);
    plot(255, 255, 0, 24'hAAAAAA);
    plot(128, 1, -1, 24'h800001);
    clear_depths();
    plot(255, 255, 0, 24'h555555);
    plot(0, 0, DEPTH_FAR, 24'h0F0F0F);
    drain();

    load_config(MAX_SCALE, MAX_WIDTH, MAX_HEIGHT);
    plot(255, 255, 1, 24'hF0F0F0);
    plot(3, 5, 100, 24'h00FFFF);
    drain();

    load_config(0, 0, 0);
    plot(0, 0, DEPTH_NEAR, 24'hFF0000);
    drain();

    load_config(15, 511, 511);
    plot(254, 7, 5, 24'h0000FF);
    drain();

    load_config(2, 1, 1);
    plot(0, 0, 7, 24'h7F7F7F);
    plot(1, 0, 8, 24'h808080);
    plot(0, 1, 9, 24'h818181);
    drain();

    load_config(3, 10, 300);
    plot(9, 200, 9, 24'hC3C3C3);
    plot(10, 0, 9, 24'h3C3C3C);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: load_config(1, 16, 16);
        1: load_config(2, $urandom_range(1, 256), $urandom_range(1, 256));
        2: load_config(MAX_SCALE, 8, 8);
        3: load_config($urandom_range(0, 15), $urandom_range(0, 511), $urandom_range(0, 511));
        4: load_config(3, MAX_WIDTH, MAX_HEIGHT);
        default: load_config($urandom_range(1, 4), $urandom_range(1, 40),
                             $urandom_range(1, 40));
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        random_word();
        if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
